[src/ray_triangle_row_parity_unit_assert.svh]
// Assertion macros shared by the ray triangle row parity unit.
`ifndef RAY_TRIANGLE_ROW_PARITY_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_ROW_PARITY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rtp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RTP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rtp assertion failed");

`endif

[src/rtp_pkg.sv]
`default_nettype none
package rtp_pkg;

	localparam int GRID_DEF = 64;

	localparam int COORD_W = 24;
	localparam int EDGE_W  = 25;
	localparam int DET_W   = 51;
	localparam int OPND_W  = 27;
	localparam int PROD_W  = 54;
	localparam int TN_W    = 80;
	localparam int QUO_W   = 32;
	localparam int DIST_W  = 23;
	localparam int ROW_W   = 64;
	localparam int HIT_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int Q_SPLIT = 26;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DIST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SPAN  = 3'd4;

	localparam logic [DIST_W-1:0] FIRST_DIST_RST = 23'd1048576;
	localparam logic [DIST_W-1:0] CELL_SPAN_RST  = 23'd23068;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] az;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by_coord;
		logic signed [COORD_W-1:0] bz;
		logic signed [COORD_W-1:0] cx_coord;
		logic signed [COORD_W-1:0] cy_coord;
		logic signed [COORD_W-1:0] cz_coord;
		logic                      last_triangle;
	} tri_in_t;

	typedef struct packed {
		logic [ROW_W-1:0] inside_row;
		logic [HIT_W-1:0] hit_count;
	} row_out_t;

	typedef struct packed {
		logic                start;
		logic [TN_W-1:0]     dividend;
		logic [DET_W-1:0]    divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PREP, ST_MUL, ST_DRAIN, ST_TEST, ST_DIV, ST_CELL, ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_DET_P, OP_DET_N, OP_U_P, OP_U_N, OP_Q0_P, OP_Q0_N, OP_Q1_P, OP_Q1_N,
		OP_Q2_P, OP_Q2_N, OP_T0_LO, OP_T0_HI, OP_T1_LO, OP_T1_HI, OP_T2_LO, OP_T2_HI
	} mac_op_t;

endpackage
`default_nettype wire

[src/rtp_mac.sv]
`default_nettype none
module rtp_mac (
	input  wire                                  clk,
	input  wire logic signed [rtp_pkg::OPND_W-1:0] a,
	input  wire logic signed [rtp_pkg::OPND_W-1:0] b,
	output logic signed [rtp_pkg::PROD_W-1:0]      prod_q
);
	import rtp_pkg::*;

	// Shared signed multiplier with a registered product.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
endmodule
`default_nettype wire

[src/rtp_div.sv]
`default_nettype none
module rtp_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire rtp_pkg::div_req_t            req,
	output logic                              done_q,
	output logic [rtp_pkg::QUO_W-1:0]         quotient
);
	import rtp_pkg::*;

	// Restoring division, one quotient bit per cycle. The upper part of the
	// dividend must already be below the divisor.
	logic [DET_W-1:0] rem_q;
	logic [QUO_W-1:0] low_q;
	logic [DET_W-1:0] div_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic [DET_W:0]   trial;
	logic             take;

	assign trial = {rem_q, low_q[QUO_W-1]};
	assign take = trial >= {1'b0, div_q};
	assign quotient = low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DET_W'(req.dividend[TN_W-1:QUO_W]);
			low_q <= req.dividend[QUO_W-1:0];
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? DET_W'(trial - {1'b0, div_q}) : trial[DET_W-1:0];
			low_q <= {low_q[QUO_W-2:0], take};
		end
	end
endmodule
`default_nettype wire

[src/ray_triangle_row_parity_unit.sv]
// Sequence: an accepted triangle passes through the edge setup, the multiply
// steps and the hit test; a hit that reaches the cells then passes through the
// 32-step divider and the walk over the cells of the row, one cell per cycle.
// Throughput: one triangle at a time; the unit stalls input while it works.
// Reset (arst_n low, asynchronous) clears the mask, the hit count and all control,
// and returns the registers to their documented reset values.
`default_nettype none
`include "ray_triangle_row_parity_unit_assert.svh"
module ray_triangle_row_parity_unit #(
	parameter int GRID = rtp_pkg::GRID_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire rtp_pkg::tri_in_t                  in_word,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output rtp_pkg::row_out_t                      out_word,
	input  wire                                    cfg_we,
	input  wire logic [rtp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [rtp_pkg::COORD_W-1:0]       cfg_wdata
);
	import rtp_pkg::*;

	localparam int CellW = (GRID > 1) ? $clog2(GRID) : 1;
	localparam int CentW = DIST_W + 1 + CellW;

	// Configuration registers.
	logic signed [COORD_W-1:0] origin_y_q, origin_z_q, start_x_q;
	logic [DIST_W-1:0]         first_dist_q, cell_span_q;

	// The word being worked on.
	tri_in_t item_q;
	state_t  state_q, state_nx;
	mac_op_t step_q;

	// Edge and ray offset vectors, exact Q.20.
	logic signed [EDGE_W-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q, tx_q, ty_q, tz_q;

	// Accumulated products: determinant, u and v numerators, cross terms and
	// the distance numerator.
	logic signed [DET_W-1:0] det_q, un_q, q0_q, q1_q, q2_q;
	logic signed [TN_W-1:0]  tn_q;

	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic                     acc_en_q;
	mac_op_t                  acc_op_q;

	logic [ROW_W-1:0]   parity_q;
	logic [HIT_W-1:0]   hit_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CellW-1:0]   cell_q;
	logic [CentW-1:0]   centre_q;
	logic               out_valid_q;
	row_out_t           out_q;

	div_req_t           div_req;
	logic               div_done;
	logic [QUO_W-1:0]   div_quo;

	// Control strobes.
	logic in_accept, hit_inc, load_out, out_free, cell_last;
	logic reject, sat;

	// Sign-corrected values used by the hit test.
	logic                    det_neg;
	logic [DET_W-1:0]        dn, uu, vv;
	logic [TN_W-1:0]         tt;
	logic [DET_W:0]          uv_sum;

	function automatic logic signed [OPND_W-1:0] ext_e(input logic signed [EDGE_W-1:0] v);
		return OPND_W'(v);
	endfunction

	function automatic logic signed [OPND_W-1:0] q_lo(input logic signed [DET_W-1:0] v);
		return $signed({1'b0, v[Q_SPLIT-1:0]});
	endfunction

	function automatic logic signed [OPND_W-1:0] q_hi(input logic signed [DET_W-1:0] v);
		logic signed [DET_W-Q_SPLIT-1:0] h;
		h = v[DET_W-1:Q_SPLIT];
		return OPND_W'(h);
	endfunction

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_q;
	assign out_free = !out_valid_q || !out_stall;
	assign cell_last = (cell_q == CellW'(GRID - 1));

	// Configuration writes; indexes past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_y_q <= '0;
			origin_z_q <= '0;
			start_x_q <= '0;
			first_dist_q <= FIRST_DIST_RST;
			cell_span_q <= CELL_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_Y:   origin_y_q <= cfg_wdata;
				CFG_ORIGIN_Z:   origin_z_q <= cfg_wdata;
				CFG_START_X:    start_x_q <= cfg_wdata;
				CFG_FIRST_DIST: first_dist_q <= cfg_wdata[DIST_W-1:0];
				CFG_CELL_SPAN:  cell_span_q <= cfg_wdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier. The distance numerator is
	// built from the cross terms split into a low unsigned and a high signed half.
	always_comb begin
		case (step_q)
			OP_DET_P: begin mul_a = ext_e(e1z_q); mul_b = ext_e(e2y_q); end
			OP_DET_N: begin mul_a = ext_e(e1y_q); mul_b = ext_e(e2z_q); end
			OP_U_P:   begin mul_a = ext_e(tz_q);  mul_b = ext_e(e2y_q); end
			OP_U_N:   begin mul_a = ext_e(ty_q);  mul_b = ext_e(e2z_q); end
			OP_Q0_P:  begin mul_a = ext_e(ty_q);  mul_b = ext_e(e1z_q); end
			OP_Q0_N:  begin mul_a = ext_e(tz_q);  mul_b = ext_e(e1y_q); end
			OP_Q1_P:  begin mul_a = ext_e(tz_q);  mul_b = ext_e(e1x_q); end
			OP_Q1_N:  begin mul_a = ext_e(tx_q);  mul_b = ext_e(e1z_q); end
			OP_Q2_P:  begin mul_a = ext_e(tx_q);  mul_b = ext_e(e1y_q); end
			OP_Q2_N:  begin mul_a = ext_e(ty_q);  mul_b = ext_e(e1x_q); end
			OP_T0_LO: begin mul_a = ext_e(e2x_q); mul_b = q_lo(q0_q); end
			OP_T0_HI: begin mul_a = ext_e(e2x_q); mul_b = q_hi(q0_q); end
			OP_T1_LO: begin mul_a = ext_e(e2y_q); mul_b = q_lo(q1_q); end
			OP_T1_HI: begin mul_a = ext_e(e2y_q); mul_b = q_hi(q1_q); end
			OP_T2_LO: begin mul_a = ext_e(e2z_q); mul_b = q_lo(q2_q); end
			OP_T2_HI: begin mul_a = ext_e(e2z_q); mul_b = q_hi(q2_q); end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	rtp_mac u_mac (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// Hit test. With the determinant made positive, u, v and u + v are checked
	// inclusively against it, and the distance must be strictly positive.
	always_comb begin
		det_neg = det_q[DET_W-1];
		dn = det_neg ? DET_W'(-det_q) : DET_W'(det_q);
		uu = det_neg ? DET_W'(-un_q) : DET_W'(un_q);
		vv = det_neg ? DET_W'(-q0_q) : DET_W'(q0_q);
		tt = det_neg ? TN_W'(-tn_q) : TN_W'(tn_q);
		uv_sum = {1'b0, uu} + {1'b0, vv};
		reject = (det_q == '0) || uu[DET_W-1] || vv[DET_W-1] || (uu > dn) ||
			(uv_sum > {1'b0, dn}) || tt[TN_W-1] || (tt == '0);
		// A quotient of 2^32 or more lies past every cell centre.
		sat = DET_W'(tt[TN_W-1:QUO_W]) >= dn;
	end

	rtp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done_q  (div_done),
		.quotient(div_quo)
	);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (in_accept) state_nx = ST_PREP;
			ST_PREP:   state_nx = ST_MUL;
			ST_MUL:    if (step_q == OP_T2_HI) state_nx = ST_DRAIN;
			ST_DRAIN:  state_nx = ST_TEST;
			ST_TEST:   state_nx = (reject || sat) ? ST_FINISH : ST_DIV;
			ST_DIV:    if (div_done) state_nx = ST_CELL;
			ST_CELL:   if (cell_last) state_nx = ST_FINISH;
			ST_FINISH: if (!item_q.last_triangle || out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// Output strobes, and the request handed to the divider.
	always_comb begin
		div_req.start = 1'b0;
		div_req.dividend = tt;
		div_req.divisor = dn;
		hit_inc = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_TEST: begin
				hit_inc = !reject;
				div_req.start = !reject && !sat;
			end
			ST_FINISH: load_out = item_q.last_triangle && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= OP_DET_P;
			acc_en_q <= 1'b0;
			acc_op_q <= OP_DET_P;
			parity_q <= '0;
			hit_q <= '0;
			out_valid_q <= 1'b0;
			cell_q <= '0;
		end else begin
			state_q <= state_nx;
			acc_en_q <= (state_q == ST_MUL);
			acc_op_q <= step_q;
			if (state_q == ST_PREP) begin
				step_q <= OP_DET_P;
			end else if (state_q == ST_MUL) begin
				step_q <= mac_op_t'(step_q + 4'd1);
			end
			if (hit_inc && hit_q != {HIT_W{1'b1}}) begin
				hit_q <= hit_q + 16'd1;
			end
			if (state_q == ST_DIV) begin
				cell_q <= '0;
			end else if (state_q == ST_CELL) begin
				if (quo_q < QUO_W'(centre_q)) begin
					parity_q[6'(cell_q)] <= ~parity_q[6'(cell_q)];
				end
				cell_q <= cell_q + CellW'(1);
			end
			// A finished row leaves through the output register, then clears.
			if (load_out) begin
				out_valid_q <= 1'b1;
				parity_q <= '0;
				hit_q <= '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= in_word;
		end
		if (state_q == ST_PREP) begin
			e1x_q <= EDGE_W'(item_q.bx) - EDGE_W'(item_q.ax);
			e1y_q <= EDGE_W'(item_q.by_coord) - EDGE_W'(item_q.ay);
			e1z_q <= EDGE_W'(item_q.bz) - EDGE_W'(item_q.az);
			e2x_q <= EDGE_W'(item_q.cx_coord) - EDGE_W'(item_q.ax);
			e2y_q <= EDGE_W'(item_q.cy_coord) - EDGE_W'(item_q.ay);
			e2z_q <= EDGE_W'(item_q.cz_coord) - EDGE_W'(item_q.az);
			tx_q <= EDGE_W'(start_x_q) - EDGE_W'(item_q.ax);
			ty_q <= EDGE_W'(origin_y_q) - EDGE_W'(item_q.ay);
			tz_q <= EDGE_W'(origin_z_q) - EDGE_W'(item_q.az);
			det_q <= '0;
			un_q <= '0;
			q0_q <= '0;
			q1_q <= '0;
			q2_q <= '0;
			tn_q <= '0;
		end else if (acc_en_q) begin
			case (acc_op_q)
				OP_DET_P: det_q <= det_q + DET_W'(prod_q);
				OP_DET_N: det_q <= det_q - DET_W'(prod_q);
				OP_U_P:   un_q <= un_q + DET_W'(prod_q);
				OP_U_N:   un_q <= un_q - DET_W'(prod_q);
				OP_Q0_P:  q0_q <= q0_q + DET_W'(prod_q);
				OP_Q0_N:  q0_q <= q0_q - DET_W'(prod_q);
				OP_Q1_P:  q1_q <= q1_q + DET_W'(prod_q);
				OP_Q1_N:  q1_q <= q1_q - DET_W'(prod_q);
				OP_Q2_P:  q2_q <= q2_q + DET_W'(prod_q);
				OP_Q2_N:  q2_q <= q2_q - DET_W'(prod_q);
				OP_T0_LO, OP_T1_LO, OP_T2_LO: tn_q <= tn_q + TN_W'(prod_q);
				OP_T0_HI, OP_T1_HI, OP_T2_HI: tn_q <= tn_q + (TN_W'(prod_q) <<< Q_SPLIT);
				default: ;
			endcase
		end
		if (div_done) begin
			quo_q <= div_quo;
			centre_q <= CentW'(first_dist_q);
		end else if (state_q == ST_CELL) begin
			centre_q <= centre_q + CentW'(cell_span_q);
		end
		if (load_out) begin
			out_q.inside_row <= parity_q;
			out_q.hit_count <= hit_q;
		end
	end

	// The divider reports completion only while the sequencer waits for it.
	`RTP_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
	// An accepted word always starts the edge setup next.
	`RTP_ASSERT_NXT(a_accept_to_prep, in_accept, state_q == ST_PREP)
	// The hit count only grows, except when a row is handed out.
	`RTP_ASSERT_NXT(a_hits_grow, !load_out, hit_q >= $past(hit_q))

endmodule
`default_nettype wire
